// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while reset is held
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/hexesc_pkg.sv =====
package hexesc_pkg;

  localparam logic [7:0] DotChar        = 8'h2e;
  localparam logic [7:0] UnderscoreChar = 8'h5f;

  typedef enum logic {
    OpEncode = 1'b0,
    OpDecode = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    PhIdle = 3'b001,
    PhHigh = 3'b010,
    PhLow  = 3'b100
  } phase_e;

  function automatic logic is_plain(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39) || (c == UnderscoreChar);
  endfunction

  // lowercase hex digit for one nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    return (nib < 4'd10) ? (8'h30 + wide) : (8'h57 + wide);
  endfunction

  // {ok, value} for an upper or lower case hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    logic       ok;
    v  = 8'h00;
    ok = 1'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v  = c - 8'h30;
      ok = 1'b1;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v  = c - 8'h57;
      ok = 1'b1;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v  = c - 8'h37;
      ok = 1'b1;
    end
    return {ok, v[3:0]};
  endfunction

endpackage

// ===== rtl/core/hex_escape_codec_unit.sv =====
// Dot-hex escape codec for a byte stream. Each input transaction carries one byte, an
// encode/decode tag and an end-of-string flag; each output transaction carries one result.
// Encoding a letter, digit or underscore, and decoding any byte, yields at most one result,
// so such items stream at one per cycle unless the output stalls; encoding any other byte
// gives a dot and two lowercase hex digits in turn from the single output register, which
// emits one result a cycle unless stalled. Decode errors are sticky until the end of the
// string and are reported on its final result.
module hex_escape_codec_unit
  import hexesc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       in_operation_i,
  input  logic [7:0] in_data_byte_i,
  input  logic       in_end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_byte_valid_o,
  output logic       out_error_o,
  output logic       out_run_last_o,
  output logic       out_string_done_o
);

  logic       work_valid_q;
  op_e        work_op_q;
  logic [7:0] work_byte_q;
  logic       work_eos_q;
  logic [1:0] idx_q;

  phase_e     phase_q;
  logic [3:0] nib_q;
  logic       err_q;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_bvalid_q;
  logic       out_err_q;
  logic       out_last_q;
  logic       out_done_q;

  logic       dec_have;
  logic [7:0] dec_b;
  phase_e     dec_phase;
  logic [3:0] dec_nib;
  logic       dec_err;
  logic [4:0] hv;

  logic       has_res;
  logic       res_final;
  logic [7:0] res_byte;
  logic       res_bvalid;
  logic       res_err;
  logic       res_last;
  logic       res_done;

  logic       out_ready;
  logic       step;
  logic       retire;
  logic       out_load;
  logic       in_accept;

  assign hv = hex_value(work_byte_q);

  always_comb begin
    dec_have  = 1'b0;
    dec_b     = 8'h00;
    dec_phase = phase_q;
    dec_nib   = nib_q;
    dec_err   = err_q;
    if (!err_q) begin
      unique case (phase_q)
        PhHigh: begin
          if (hv[4]) begin
            dec_nib   = hv[3:0];
            dec_phase = PhLow;
          end else begin
            dec_err = 1'b1;
          end
        end
        PhLow: begin
          if (hv[4]) begin
            dec_b     = {nib_q, hv[3:0]};
            dec_have  = 1'b1;
            dec_phase = PhIdle;
          end else begin
            dec_err = 1'b1;
          end
        end
        default: begin
          dec_phase = PhIdle;
          if (is_plain(work_byte_q)) begin
            dec_b    = work_byte_q;
            dec_have = 1'b1;
          end else if (work_byte_q == DotChar) begin
            dec_phase = PhHigh;
          end else begin
            dec_err = 1'b1;
          end
        end
      endcase
    end
    // escape cut off by the end of the string
    if (work_eos_q && dec_phase != PhIdle) begin
      dec_err = 1'b1;
    end
  end

  always_comb begin
    has_res    = 1'b0;
    res_final  = 1'b1;
    res_byte   = 8'h00;
    res_bvalid = 1'b0;
    res_err    = 1'b0;
    res_last   = 1'b0;
    res_done   = 1'b0;
    unique case (work_op_q)
      OpEncode: begin
        has_res    = 1'b1;
        res_bvalid = 1'b1;
        if (is_plain(work_byte_q)) begin
          res_byte = work_byte_q;
          res_last = 1'b1;
          res_done = work_eos_q;
        end else begin
          unique case (idx_q)
            2'd0: begin
              res_byte  = DotChar;
              res_final = 1'b0;
            end
            2'd1: begin
              res_byte  = hex_digit(work_byte_q[7:4]);
              res_final = 1'b0;
            end
            default: begin
              res_byte = hex_digit(work_byte_q[3:0]);
              res_last = 1'b1;
              res_done = work_eos_q;
            end
          endcase
        end
      end
      default: begin
        has_res    = dec_have || work_eos_q;
        res_byte   = dec_b;
        res_bvalid = dec_have;
        res_err    = work_eos_q && dec_err;
        res_last   = 1'b1;
        res_done   = work_eos_q;
      end
    endcase
  end

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign step       = work_valid_q && (!has_res || out_ready);
  assign retire     = step && res_final;
  assign out_load   = step && has_res;
  assign in_stall_o = work_valid_q && !retire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      idx_q        <= 2'd0;
      phase_q      <= PhIdle;
      nib_q        <= 4'h0;
      err_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_accept) begin
        work_valid_q <= 1'b1;
      end else if (retire) begin
        work_valid_q <= 1'b0;
      end
      if (retire) begin
        idx_q <= 2'd0;
        if (work_eos_q) begin
          phase_q <= PhIdle;
          nib_q   <= 4'h0;
          err_q   <= 1'b0;
        end else if (work_op_q == OpDecode) begin
          phase_q <= dec_phase;
          nib_q   <= dec_nib;
          err_q   <= dec_err;
        end
      end else if (step) begin
        idx_q <= idx_q + 2'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      work_op_q   <= op_e'(in_operation_i);
      work_byte_q <= in_data_byte_i;
      work_eos_q  <= in_end_of_string_i;
    end
    if (out_load) begin
      out_byte_q   <= res_byte;
      out_bvalid_q <= res_bvalid;
      out_err_q    <= res_err;
      out_last_q   <= res_last;
      out_done_q   <= res_done;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_byte_o        = out_byte_q;
  assign out_byte_valid_o  = out_bvalid_q;
  assign out_error_o       = out_err_q;
  assign out_run_last_o    = out_last_q;
  assign out_string_done_o = out_done_q;

endmodule

// ===== rtl/core/hexesc_checker.sv =====
`include "assert_macros.svh"

module hexesc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       out_byte_valid_o,
  input logic       out_error_o,
  input logic       out_run_last_o,
  input logic       out_string_done_o
);

  // a stalled output transaction holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_byte_o) && $stable(out_error_o) && $stable(out_string_done_o))
  // end of string is always the last result of its input
  `ASSERT_IMPL(a_done_last, clk_i, rst_ni, out_valid_o && out_string_done_o, out_run_last_o)
  // errors are only reported at the end of a string
  `ASSERT_IMPL(a_err_done, clk_i, rst_ni, out_valid_o && out_error_o, out_string_done_o)
  // an empty result only closes a string and carries a zero byte
  `ASSERT_IMPL(a_empty_res, clk_i, rst_ni, out_valid_o && !out_byte_valid_o, out_string_done_o && out_byte_o == 8'h00)

endmodule

bind hex_escape_codec_unit hexesc_checker u_hexesc_checker (.*);
